// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the loss accumulator.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define RLA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define RLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rla_pkg.sv
// Types and constants of the regression loss accumulator.
// No dependencies; imported by every module of the block but rla_div.
package rla_pkg;

  typedef enum logic [1:0] {
    KIND_ELEM   = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_REPORT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_ELEM   = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_REPORT = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_L2    = 2'd0,
    MODE_L1    = 2'd1,
    MODE_HUBER = 2'd2
  } mode_e;

  localparam logic [1:0] CFG_LOSS_MODE   = 2'd0;
  localparam logic [1:0] CFG_HUBER_DELTA = 2'd1;
  localparam logic [1:0] CFG_TARGET_CLS  = 2'd2;
  localparam logic [1:0] CFG_FRAME_ROWS  = 2'd3;

  localparam int CFG_DATA_W = 23;
  localparam logic [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [22:0] DELTA_RESET = 23'd65536;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [23:0] model_output;
    logic signed [23:0] target_value;
    logic [9:0]         target_class;
  } in_t;

  typedef struct packed {
    logic signed [23:0] gradient;
    logic [62:0]        squared_mean;
    logic [62:0]        absolute_mean;
    logic [62:0]        huber_mean;
    logic [62:0]        selected_loss;
    logic [31:0]        frames_seen;
    logic               no_samples;
  } out_t;

  typedef struct packed {
    op_e                op;
    logic signed [23:0] model_output;
    logic signed [23:0] target_value;
    logic [9:0]         target_class;
  } q_item_t;

endpackage

// File: rtl/core/rla_queue.sv
// Two-entry queue that decouples the accepting front from the executing back.
// Depends on rla_pkg for the queued item type.
module rla_queue import rla_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    avail,
  output q_item_t pop_data
);

  q_item_t    mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign avail    = (cnt_r != 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/core/rla_div.sv
// Iterative restoring divider, one quotient bit per cycle, 64 by 32 bits.
// No dependencies; used by the back end for report means.
module rla_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [32:0] rem_r;
  logic [63:0] quo_r;
  logic [31:0] dvs_r;
  logic [6:0]  cnt_r;
  logic        done_r;
  logic [32:0] rem_sh, rem_sub;
  logic        bit_q;

  assign rem_sh   = {rem_r[31:0], quo_r[63]};
  assign rem_sub  = rem_sh - {1'b0, dvs_r};
  assign bit_q    = (rem_sh >= {1'b0, dvs_r});
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 7'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= 7'd64;
      end else if (cnt_r != 7'd0) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 33'd0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (cnt_r != 7'd0) begin
      rem_r <= bit_q ? rem_sub : rem_sh;
      quo_r <= {quo_r[62:0], bit_q};
    end
  end

endmodule

// File: rtl/core/rla_back.sv
// Back end: executes queued items, keeps the sums and the output register.
// Depends on rla_pkg, rla_div and assert_macros.svh.
`include "assert_macros.svh"
module rla_back import rla_pkg::*; #(
  parameter int MAX_ROWS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_avail,
  input  q_item_t               q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data
);

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW_A  = $clog2(MAX_ROWS + 1) + 1;
  localparam int CW    = (CW_A > 12) ? CW_A : 12;
  localparam logic [CW-1:0] MAX_ROWS_C = CW'(MAX_ROWS);

  typedef enum logic [2:0] {
    S_IDLE, S_E1, S_E2, S_E3, S_DSTART, S_DWAIT, S_OUT
  } state_e;

  state_e             state_r;
  logic [1:0]         mode_r;
  logic [22:0]        delta_r;
  logic               cls_r;
  logic [10:0]        rows_r;
  logic [63:0]        sq_sum_r, ab_sum_r, hu_sum_r;
  logic [31:0]        frames_r;
  logic [ROW_W-1:0]   row_r;
  q_item_t            item_r;
  logic [23:0]        err_r;
  logic signed [23:0] grad_r;
  logic [47:0]        sq_prod_r, hu_prod_r;
  logic               hu_big_r;
  out_t               res_r, out_r;
  logic               out_valid_r;
  logic [1:0]         dsel_r;

  logic               hit;
  logic signed [24:0] t_val, diff, d_s, grad_w;
  logic [24:0]        err_w;
  logic [24:0]        two_err_m_d;
  logic [46:0]        sq_t, hu_t;
  logic [39:0]        ab_t;
  logic [63:0]        sq_add, ab_add, hu_add;
  logic [CW-1:0]      eff_rows, row_next;
  logic               wrap;
  logic [63:0]        div_dividend, div_q;
  logic               div_start, div_done;

  assign hit   = ({{(CW-10){1'b0}}, item_r.target_class} == {{(CW-ROW_W){1'b0}}, row_r});
  assign t_val = cls_r ? (hit ? 25'sd65536 : 25'sd0) : 25'(item_r.target_value);
  assign diff  = t_val - 25'(item_r.model_output);
  assign err_w = diff[24] ? 25'(-diff) : 25'(diff);
  assign d_s   = signed'({2'b00, delta_r});

  always_comb begin
    case (mode_r)
      MODE_L1: begin
        grad_w = (diff > 0) ? 25'sd65536 : ((diff < 0) ? -25'sd65536 : 25'sd0);
      end
      MODE_HUBER: begin
        grad_w = (diff > d_s) ? d_s : ((diff < -d_s) ? -d_s : diff);
      end
      default: begin
        grad_w = (diff > 25'sd8388607) ? 25'sd8388607 :
                 ((diff < -25'sd8388608) ? -25'sd8388608 : diff);
      end
    endcase
  end

  assign two_err_m_d = {err_r, 1'b0} - {2'b00, delta_r};
  assign sq_t   = sq_prod_r[47:1];
  assign hu_t   = hu_big_r ? hu_prod_r[47:1] : sq_t;
  assign ab_t   = {err_r, 16'd0};
  assign sq_add = sq_sum_r + {17'd0, sq_t};
  assign ab_add = ab_sum_r + {24'd0, ab_t};
  assign hu_add = hu_sum_r + {17'd0, hu_t};

  always_comb begin
    eff_rows = {{(CW-11){1'b0}}, rows_r};
    if (eff_rows == '0) eff_rows = CW'(1);
    if (eff_rows > MAX_ROWS_C) eff_rows = MAX_ROWS_C;
  end
  assign row_next = {{(CW-ROW_W){1'b0}}, row_r} + CW'(1);
  assign wrap     = (row_next >= eff_rows);

  always_comb begin
    case (dsel_r)
      2'd0:    div_dividend = sq_sum_r;
      2'd1:    div_dividend = ab_sum_r;
      default: div_dividend = hu_sum_r;
    endcase
  end
  assign div_start = (state_r == S_DSTART);

  rla_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (frames_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_pop     = (state_r == S_IDLE) && q_avail;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_L2;
      delta_r     <= DELTA_RESET;
      cls_r       <= 1'b0;
      rows_r      <= 11'd1;
      sq_sum_r    <= '0;
      ab_sum_r    <= '0;
      hu_sum_r    <= '0;
      frames_r    <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      dsel_r      <= 2'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOSS_MODE:   mode_r  <= cfg_data[1:0];
          CFG_HUBER_DELTA: delta_r <= cfg_data[22:0];
          CFG_TARGET_CLS:  cls_r   <= cfg_data[0];
          CFG_FRAME_ROWS:  rows_r  <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && (state_r != S_OUT)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_avail) begin
            item_r <= q_data;
            res_r  <= {24'd0, 252'd0,
                       (q_data.op == OP_CLEAR) ? 32'd0 : frames_r,
                       (q_data.op == OP_REPORT) && (frames_r == '0)};
            case (q_data.op)
              OP_ELEM: state_r <= S_E1;
              OP_CLEAR: begin
                sq_sum_r <= '0;
                ab_sum_r <= '0;
                hu_sum_r <= '0;
                frames_r <= '0;
                row_r    <= '0;
                state_r  <= S_OUT;
              end
              OP_REPORT: begin
                dsel_r <= 2'd0;
                if (frames_r == '0) begin
                  state_r <= S_OUT;
                end else begin
                  state_r <= S_DSTART;
                end
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_E1: begin
          err_r   <= err_w[23:0];
          grad_r  <= grad_w[23:0];
          state_r <= S_E2;
        end
        S_E2: begin
          sq_prod_r <= err_r * err_r;
          hu_prod_r <= delta_r * two_err_m_d;
          hu_big_r  <= ({1'b0, err_r} > {2'b00, delta_r});
          state_r   <= S_E3;
        end
        S_E3: begin
          sq_sum_r <= sq_add[63] ? SUM_MAX : sq_add;
          ab_sum_r <= ab_add[63] ? SUM_MAX : ab_add;
          hu_sum_r <= hu_add[63] ? SUM_MAX : hu_add;
          res_r.gradient <= grad_r;
          if (wrap) begin
            row_r <= '0;
            if (frames_r != '1) begin
              frames_r <= frames_r + 32'd1;
              res_r.frames_seen <= frames_r + 32'd1;
            end
          end else begin
            row_r <= row_next[ROW_W-1:0];
          end
          state_r <= S_OUT;
        end
        S_DSTART: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            case (dsel_r)
              2'd0: begin
                res_r.squared_mean <= div_q[62:0];
                if (mode_r != MODE_L1 && mode_r != MODE_HUBER)
                  res_r.selected_loss <= div_q[62:0];
              end
              2'd1: begin
                res_r.absolute_mean <= div_q[62:0];
                if (mode_r == MODE_L1) res_r.selected_loss <= div_q[62:0];
              end
              default: begin
                res_r.huber_mean <= div_q[62:0];
                if (mode_r == MODE_HUBER) res_r.selected_loss <= div_q[62:0];
              end
            endcase
            if (dsel_r == 2'd2) begin
              state_r <= S_OUT;
            end else begin
              dsel_r  <= dsel_r + 2'd1;
              state_r <= S_DSTART;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `RLA_ASSERT(a_sums_bounded, !sq_sum_r[63] && !ab_sum_r[63] && !hu_sum_r[63], "sum overflow")
  `RLA_ASSERT(a_nosamp_zero, !(out_valid_r && out_r.no_samples) || (out_r.selected_loss == '0), "no_samples with nonzero mean")
  `RLA_ASSERT_NEXT(a_out_load, (state_r == S_OUT) && (!out_valid_r || !out_stall), out_valid_r && (state_r == S_IDLE), "result not delivered")
  `RLA_ASSERT(a_row_range, {{(CW-ROW_W){1'b0}}, row_r} < MAX_ROWS_C, "row counter out of range")

endmodule

// File: rtl/core/regression_loss_accumulator.sv
// Top level of the regression loss accumulator: front decode and queue feed
// the back end. Depends on rla_pkg, rla_queue and rla_back.
//
// Usage: items enter on in_valid/in_stall/in_data and results leave on
// out_valid/out_stall/out_data, one result per item, in order. An item is
// taken at a clock edge with valid high and stall low. Element items carry an
// output and a target and return a gradient while adding to three loss sums;
// clear items zero the statistics; report items return the means.
// An element item passes from the queue through three execution stages to
// the output register. A report runs three 64-step divisions in one shared
// divider.
// Items are executed one at a time. The two-entry queue keeps accepting while
// the back end works or while a result waits under out_stall; in_stall rises
// when the queue is full. Configuration is written by the user only while
// idle, on cfg_we/cfg_index/cfg_data; the block does not enforce this.
// Synchronous active-low reset clears the sums, counters, queue and config.
module regression_loss_accumulator import rla_pkg::*; #(
  parameter int MAX_ROWS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  q_item_t q_in, q_out;
  logic    q_full, q_avail, q_pop, q_push;

  always_comb begin
    q_in.model_output = in_data.model_output;
    q_in.target_value = in_data.target_value;
    q_in.target_class = in_data.target_class;
    case (in_data.kind)
      KIND_ELEM:   q_in.op = OP_ELEM;
      KIND_CLEAR:  q_in.op = OP_CLEAR;
      KIND_REPORT: q_in.op = OP_REPORT;
      default:     q_in.op = OP_NONE;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  rla_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_data  (q_out)
  );

  rla_back #(.MAX_ROWS(MAX_ROWS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_avail   (q_avail),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: bench/tb_top.sv
// Self-checking testbench of the regression loss accumulator.
// A scoreboard class predicts each result from the accepted items and the
// register settings; it depends on rla_pkg and regression_loss_accumulator.
`timescale 1ns / 1ps

module tb_top;
  import rla_pkg::*;

  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam longint unsigned ONE_Q16 = 65536;
  localparam int ROW_LIMIT = 1024;
  localparam int CYCLE_LIMIT = 1000000;

  class loss_scoreboard;
    logic [1:0] loss_mode;
    logic [22:0] delta;
    logic is_class;
    logic [10:0] rows;
    longint unsigned sq_sum, abs_sum, hub_sum;
    int unsigned frames;
    int unsigned row;
    out_t expected_q[$];
    int errors;

    function new();
      loss_mode = MODE_L2;
      delta = DELTA_RESET;
      is_class = 1'b0;
      rows = 11'd1;
      sq_sum = 0;
      abs_sum = 0;
      hub_sum = 0;
      frames = 0;
      row = 0;
      errors = 0;
    endfunction

    function longint unsigned sat_add(longint unsigned a, longint unsigned b);
      if (b > SUM_MAX - a) return SUM_MAX;
      return a + b;
    endfunction

    function void note(in_t it);
      out_t e;
      longint o, t, diff, g, d;
      longint unsigned err, sq, hu;
      int unsigned r;
      e = '0;
      if (it.kind == KIND_ELEM) begin
        o = longint'(it.model_output);
        if (is_class) t = (int'(it.target_class) == row) ? ONE_Q16 : 0;
        else t = longint'(it.target_value);
        diff = t - o;
        d = longint'(delta);
        if (loss_mode == MODE_L1) begin
          g = diff > 0 ? ONE_Q16 : (diff < 0 ? -ONE_Q16 : 0);
        end else if (loss_mode == MODE_HUBER) begin
          g = diff > d ? d : (diff < -d ? -d : diff);
        end else begin
          g = diff > 8388607 ? 8388607 : (diff < -8388608 ? -8388608 : diff);
        end
        e.gradient = g[23:0];
        err = diff < 0 ? -diff : diff;
        sq = (err * err) >> 1;
        if (err <= d) hu = sq;
        else hu = (d * (2 * err - d)) >> 1;
        sq_sum = sat_add(sq_sum, sq);
        abs_sum = sat_add(abs_sum, err << 16);
        hub_sum = sat_add(hub_sum, hu);
        r = rows == 0 ? 1 : (rows > ROW_LIMIT ? ROW_LIMIT : rows);
        if (row + 1 >= r) begin
          row = 0;
          if (frames != 32'hFFFF_FFFF) frames++;
        end else begin
          row++;
        end
      end else if (it.kind == KIND_CLEAR) begin
        sq_sum = 0;
        abs_sum = 0;
        hub_sum = 0;
        frames = 0;
        row = 0;
      end else if (it.kind == KIND_REPORT) begin
        if (frames == 0) begin
          e.no_samples = 1'b1;
        end else begin
          e.squared_mean = 63'(sq_sum / frames);
          e.absolute_mean = 63'(abs_sum / frames);
          e.huber_mean = 63'(hub_sum / frames);
          e.selected_loss = loss_mode == MODE_L1 ? e.absolute_mean :
                            (loss_mode == MODE_HUBER ? e.huber_mean : e.squared_mean);
        end
      end
      e.frames_seen = frames;
      expected_q.push_back(e);
    endfunction

    function void check(out_t got);
      out_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result %h", got);
        return;
      end
      e = expected_q.pop_front();
      if (got.gradient !== e.gradient || got.squared_mean !== e.squared_mean ||
          got.absolute_mean !== e.absolute_mean || got.huber_mean !== e.huber_mean ||
          got.selected_loss !== e.selected_loss || got.frames_seen !== e.frames_seen ||
          got.no_samples !== e.no_samples) begin
        errors++;
        if (errors <= 10) begin
          $display("Result mismatch: grad exp %0d got %0d, sq exp %0d got %0d",
                   e.gradient, got.gradient, e.squared_mean, got.squared_mean);
          $display("  abs exp %0d got %0d, huber exp %0d got %0d",
                   e.absolute_mean, got.absolute_mean, e.huber_mean, got.huber_mean);
          $display("  sel exp %0d got %0d, frames exp %0d got %0d, none exp %b got %b",
                   e.selected_loss, got.selected_loss, e.frames_seen, got.frames_seen,
                   e.no_samples, got.no_samples);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  loss_scoreboard sb = new();
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int cycles = 0;

  regression_loss_accumulator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check(out_data);
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send(in_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note(it);
    @(negedge clk);
  endtask

  task automatic send_fields(logic [1:0] kind, int o, int t, int cls);
    in_t it;
    it.kind = kind;
    it.model_output = 24'(o);
    it.target_value = 24'(t);
    it.target_class = 10'(cls);
    send(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, int value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= CFG_DATA_W'(value);
    @(negedge clk);
  endtask

  task automatic configure(logic [1:0] mode, int delta, bit cls, int rows);
    write_reg(CFG_LOSS_MODE, int'(mode));
    write_reg(CFG_HUBER_DELTA, delta);
    write_reg(CFG_TARGET_CLS, int'(cls));
    write_reg(CFG_FRAME_ROWS, rows);
    cfg_we <= 1'b0;
    sb.loss_mode = mode;
    sb.delta = 23'(delta);
    sb.is_class = cls;
    sb.rows = 11'(rows);
    @(negedge clk);
  endtask

  function automatic int rand_q16();
    int v;
    if ($urandom_range(2) == 0) v = $urandom_range(16777215);
    else v = $urandom_range(1048575) - 524288;
    return {{8{v[23]}}, v[23:0]};
  endfunction

  task automatic random_item(int rows);
    int r;
    int cls;
    logic [1:0] kind;
    r = $urandom_range(99);
    kind = r < 86 ? KIND_ELEM : (r < 90 ? KIND_CLEAR : (r < 97 ? KIND_REPORT : KIND_UNKNOWN));
    cls = $urandom_range(1) ? $urandom_range(rows > 8 ? 8 : rows) : $urandom_range(1023);
    send_fields(kind, rand_q16(), rand_q16(), cls);
  endtask

  initial begin
    int rows;
    int dsel;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_fields(KIND_REPORT, 0, 0, 0);
    send_fields(KIND_ELEM, -8388608, 8388607, 0);
    send_fields(KIND_ELEM, 8388607, -8388608, 1023);
    send_fields(KIND_ELEM, 12345, 12345, 0);
    send_fields(KIND_UNKNOWN, -1, -1, 1023);
    send_fields(KIND_REPORT, 0, 0, 0);
    drain();
    configure(MODE_L1, 1, 1'b0, 0);
    send_fields(KIND_ELEM, 100, -100, 0);
    send_fields(KIND_ELEM, -100, 100, 0);
    send_fields(KIND_REPORT, 0, 0, 0);
    drain();
    configure(MODE_HUBER, 0, 1'b0, 2047);
    send_fields(KIND_ELEM, 70000, -5, 0);
    send_fields(KIND_CLEAR, 0, 0, 0);
    drain();
    configure(MODE_HUBER, 8388607, 1'b1, 4);
    send_fields(KIND_ELEM, 1000, 0, 0);
    send_fields(KIND_ELEM, -8388608, 0, 0);
    send_fields(KIND_ELEM, 65536, 0, 2);
    send_fields(KIND_REPORT, 0, 0, 0);
    drain();
    configure(MODE_SPARE, 65536, 1'b1, 2);
    send_fields(KIND_ELEM, 3, 0, 1);
    send_fields(KIND_ELEM, 65536, 0, 1);
    send_fields(KIND_ELEM, -65536, 0, 0);
    send_fields(KIND_REPORT, 0, 0, 0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct = phase == 1 || phase == 3 ? (phase == 1 ? 69 : 29) : 0;
      stall_pct = phase == 2 ? 69 : (phase == 3 ? 29 : 0);
      for (int blk = 0; blk < 4; blk++) begin
        r_sel: begin
          dsel = $urandom_range(3);
          case ($urandom_range(5))
            0: rows = 1;
            1: rows = 1024;
            2: rows = 2047;
            3: rows = 0;
            default: rows = $urandom_range(8, 2);
          endcase
        end
        configure(2'($urandom_range(3)),
                  dsel == 0 ? 0 : (dsel == 1 ? 8388607 : $urandom_range(8388607)),
                  1'($urandom_range(1)), rows);
        send_fields(KIND_CLEAR, 0, 0, 0);
        if (phase == 0 && blk == 1) begin
          hold_cycles = 400;
          for (int i = 0; i < 20; i++) random_item(rows);
        end
        for (int i = 0; i < 85; i++) random_item(rows);
        send_fields(KIND_REPORT, 0, 0, 0);
        drain();
      end
    end

    stall_pct = 0;
    drain();
    repeat (250) @(negedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
